@@ rtl/msp_pkg.sv @@
// Shared types and constants for the Metropolis spin proposal block.
package msp_pkg;

  // Spin and payload widths
  localparam int SPIN_W      = 3;
  localparam int SPIN_STATES = 5;
  localparam int COUNT_BITS  = 20;
  localparam int TOTAL_W     = 20;

  // Generator constants (xoshiro256+)
  localparam int GEN_W   = 64;
  localparam int ROT_A   = 45;
  localparam int SHIFT_B = 17;

  // Configuration register map
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int THRESH_W   = 32;

  localparam logic [2:0] REG_SEED0   = 3'd0;
  localparam logic [2:0] REG_SEED1   = 3'd1;
  localparam logic [2:0] REG_SEED2   = 3'd2;
  localparam logic [2:0] REG_SEED3   = 3'd3;
  localparam logic [2:0] REG_THRESH1 = 3'd4;
  localparam logic [2:0] REG_THRESH2 = 3'd5;
  localparam logic [2:0] REG_THRESH3 = 3'd6;
  localparam logic [2:0] REG_THRESH4 = 3'd7;

  // Input kinds carried on tuser
  localparam logic ACT_PROPOSE = 1'b0;
  localparam logic ACT_RESEED  = 1'b1;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // One result item
  typedef struct packed {
    logic [TOTAL_W-1:0] accepted_total;
    logic               accepted;
    logic [SPIN_W-1:0]  proposed_spin;
  } out_item_t;

  // Reduce a sum of at most 11 modulo the number of spin states
  function automatic logic [SPIN_W-1:0] spin_mod(input logic [3:0] sum);
    logic [3:0] v;
    v = sum;
    if (v >= 4'(2 * SPIN_STATES)) begin
      v = v - 4'(2 * SPIN_STATES);
    end else if (v >= 4'(SPIN_STATES)) begin
      v = v - 4'(SPIN_STATES);
    end
    return v[SPIN_W-1:0];
  endfunction

endpackage

@@ rtl/metropolis_spin_proposal.sv @@
// Top level: Metropolis spin proposal and acceptance with a xoshiro256+ generator.
//
// Usage:
//   in_*  : one item per site. in_tuser = action (propose or reseed),
//           in_tdata = current spin and a sweep-start flag.
//   out_* : one result per input item: proposed spin, accept flag and the
//           saturating accepted-move count.
//   cfg_* : APB-style port, 64-bit data, register i at byte address 8*i
//           (four seed words, then four Q0.32 thresholds). pready is always high.
// Results are registered in the output register, or in the skid stage while it stalls.
// Throughput: one item per cycle while in_tready is high; the generator step, the spin
// sum mod 5 and the 32-bit threshold compare are all combinational between the
// input handshake and the result register.
// Reset: generator state and count clear to zero, seeds to 1,0,0,0 and
// thresholds to zero; the generator draws zeros until a reseed item arrives.
// Stall: a two-entry output register and skid stage holds results; in_tready
// drops only once both are full, and no item is lost or repeated.
module metropolis_spin_proposal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] current_spin, [3] sweep_start, [7:4] zero
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] proposed_spin, [3] accepted, [23:4] accepted_total
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import msp_pkg::*;

  // Configuration registers
  logic [GEN_W-1:0]    seed_r   [4];
  logic [THRESH_W-1:0] thresh_r [4];
  logic [2:0]          cfg_idx;
  logic                cfg_wr;

  // Generator state and accepted-move count
  logic [GEN_W-1:0]      gen_r   [4];
  logic [GEN_W-1:0]      gen_nxt [4];
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;

  // Output register and skid stage
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      skid_valid_r;
  out_item_t skid_item_r;

  logic      push;
  logic      pop;
  out_item_t new_item;

  // Input field decode
  logic              action;
  logic [SPIN_W-1:0] cur_spin;
  logic              sweep;

  // Datapath
  logic [GEN_W-1:0]    word;
  logic [GEN_W-1:0]    t_shift;
  logic [GEN_W-1:0]    s2x;
  logic [GEN_W-1:0]    s3x;
  logic [GEN_W-1:0]    s1x;
  logic [2:0]          offset;
  logic [3:0]          spin_sum;
  logic [SPIN_W-1:0]   proposed;
  logic [SPIN_W-1:0]   de;
  logic [1:0]          thr_sel;
  logic                acc;
  logic [COUNT_BITS-1:0] count_base;

  assign action   = in_tuser;
  assign cur_spin = in_tdata[2:0];
  assign sweep    = in_tdata[3];

  assign push = in_tvalid && in_tready;
  assign pop  = out_valid_r && out_tready;

  // APB access
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_SEED0:   cfg_prdata = seed_r[0];
      REG_SEED1:   cfg_prdata = seed_r[1];
      REG_SEED2:   cfg_prdata = seed_r[2];
      REG_SEED3:   cfg_prdata = seed_r[3];
      REG_THRESH1: cfg_prdata = CFG_DATA_W'(thresh_r[0]);
      REG_THRESH2: cfg_prdata = CFG_DATA_W'(thresh_r[1]);
      REG_THRESH3: cfg_prdata = CFG_DATA_W'(thresh_r[2]);
      REG_THRESH4: cfg_prdata = CFG_DATA_W'(thresh_r[3]);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r[0] <= GEN_W'(1);
      seed_r[1] <= '0;
      seed_r[2] <= '0;
      seed_r[3] <= '0;
      for (int i = 0; i < 4; i++) begin
        thresh_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (!cfg_idx[2]) begin
        seed_r[cfg_idx[1:0]] <= cfg_pwdata;
      end else begin
        thresh_r[cfg_idx[1:0]] <= cfg_pwdata[THRESH_W-1:0];
      end
    end
  end

  // Generator output and one xoshiro256+ step
  assign word    = gen_r[0] + gen_r[3];
  assign t_shift = gen_r[1] << SHIFT_B;
  assign s2x     = gen_r[2] ^ gen_r[0];
  assign s3x     = gen_r[3] ^ gen_r[1];
  assign s1x     = gen_r[1] ^ s2x;

  always_comb begin
    if (action == ACT_RESEED) begin
      for (int i = 0; i < 4; i++) begin
        gen_nxt[i] = seed_r[i];
      end
    end else begin
      gen_nxt[0] = gen_r[0] ^ s3x;
      gen_nxt[1] = s1x;
      gen_nxt[2] = s2x ^ t_shift;
      gen_nxt[3] = {s3x[GEN_W-1-ROT_A:0], s3x[GEN_W-1:GEN_W-ROT_A]};
    end
  end

  // Proposal and acceptance test
  assign offset   = 3'd1 + {1'b0, word[63:62]};
  assign spin_sum = {1'b0, cur_spin} + {1'b0, offset};
  assign proposed = spin_mod(spin_sum);
  assign de       = proposed - cur_spin;
  assign thr_sel  = 2'(de - 3'd1);

  always_comb begin
    if (action == ACT_RESEED) begin
      acc = 1'b0;
    end else if (proposed <= cur_spin) begin
      acc = 1'b1;
    end else begin
      acc = thresh_r[thr_sel] > word[THRESH_W-1:0];
    end
  end

  // Saturating count, cleared at sweep start
  always_comb begin
    count_base = sweep ? '0 : count_r;
    if (acc && (count_base != {COUNT_BITS{1'b1}})) begin
      count_nxt = count_base + COUNT_BITS'(1);
    end else begin
      count_nxt = count_base;
    end
  end

  always_comb begin
    new_item.proposed_spin  = (action == ACT_RESEED) ? '0 : proposed;
    new_item.accepted       = acc;
    new_item.accepted_total = TOTAL_W'(count_nxt);
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        gen_r[i] <= '0;
      end
      count_r <= '0;
    end else if (push) begin
      for (int i = 0; i < 4; i++) begin
        gen_r[i] <= gen_nxt[i];
      end
      count_r <= count_nxt;
    end
  end

  // Output register with skid stage
  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (push) begin
        out_item_r <= new_item;
      end
    end else if (push) begin
      skid_item_r <= new_item;
    end
  end

endmodule
